/* rtl/core/pst_pkg.sv */
package pst_pkg;

   // Default sizing of the task table
   localparam int MAX_TASKS_DEF   = 8;
   localparam int PERIOD_BITS_DEF = 16;

   // Fixed field widths of the words
   localparam int KIND_W   = 2;
   localparam int TAG_W    = 8;
   localparam int PERIOD_W = 16;
   localparam int PRI_W    = 8;
   localparam int STATUS_W = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_CREATE = 2'd0,
      KIND_DELETE = 2'd1,
      KIND_TICK   = 2'd2,
      KIND_UNUSED = 2'd3
   } kind_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK          = 2'd0,
      ST_FULL        = 2'd1,
      ST_NOT_FOUND   = 2'd2,
      ST_ZERO_PERIOD = 2'd3
   } status_type;

   // Command broadcast from the sequencer to every cell
   typedef enum logic [2:0] {
      OP_NONE,
      OP_CREATE,
      OP_DELETE,
      OP_TICK,
      OP_CLEAR
   } cell_op_type;

   typedef struct packed {
      cell_op_type      op;
      logic [TAG_W-1:0] tag;
      logic [PRI_W-1:0] pri;
   } cell_cmd_type;

   typedef struct packed {
      logic [KIND_W-1:0]   kind;
      logic [TAG_W-1:0]    task_tag;
      logic [PERIOD_W-1:0] period;
      logic [PRI_W-1:0]    priority_req;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic                dispatched;
      logic [TAG_W-1:0]    run_tag;
      logic                last;
   } rsp_word_type;

endpackage

/* rtl/core/pst_if.sv */
interface pst_req_if
   import pst_pkg::*;
   ();
   logic         valid;
   logic         ready;
   req_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface pst_rsp_if
   import pst_pkg::*;
   ();
   logic         valid;
   logic         ready;
   rsp_word_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

/* rtl/core/pst_cell.sv */
module pst_cell
   import pst_pkg::*;
#(
   parameter int PERIOD_BITS = PERIOD_BITS_DEF,
   parameter int IDX_W       = 3,
   parameter int SLOT        = 0
) (
   input  logic                   clock,
   input  logic                   reset,
   input  cell_cmd_type           cmd,
   input  logic [PERIOD_BITS-1:0] cmd_period,
   input  logic [IDX_W-1:0]       cmd_idx,
   // candidate from the lower neighbor
   input  logic                   cand_valid_i,
   input  logic [PRI_W-1:0]       cand_pri_i,
   input  logic [TAG_W-1:0]       cand_tag_i,
   input  logic [IDX_W-1:0]       cand_slot_i,
   // candidate to the upper neighbor
   output logic                   cand_valid_o,
   output logic [PRI_W-1:0]       cand_pri_o,
   output logic [TAG_W-1:0]       cand_tag_o,
   output logic [IDX_W-1:0]       cand_slot_o,
   output logic                   ready_o,
   output logic                   match_o
);

   logic [TAG_W-1:0]       tag_ff;
   logic [PERIOD_BITS-1:0] period_ff;
   logic [PERIOD_BITS-1:0] countdown_ff;
   logic [PRI_W-1:0]       pri_ff;
   logic                   live_ff;
   logic                   ready_ff;
   logic                   cand_valid_ff;
   logic [PRI_W-1:0]       cand_pri_ff;
   logic [TAG_W-1:0]       cand_tag_ff;
   logic [IDX_W-1:0]       cand_slot_ff;

   logic [PERIOD_BITS-1:0] dec;
   logic                   take_own;
   logic                   mine;

   assign mine    = (cmd_idx == IDX_W'(SLOT));
   assign dec     = countdown_ff - PERIOD_BITS'(1);
   assign match_o = live_ff && (tag_ff == cmd.tag);
   assign ready_o = ready_ff;

   // own entry wins only on strictly higher priority: lower slots keep ties
   assign take_own = ready_ff && (!cand_valid_i || (pri_ff > cand_pri_i));

   // task entry
   always_ff @(posedge clock) begin
      if (reset) begin
         live_ff  <= 1'b0;
         ready_ff <= 1'b0;
      end else begin
         case (cmd.op)
            OP_CREATE: begin
               if (mine) begin
                  tag_ff       <= cmd.tag;
                  pri_ff       <= cmd.pri;
                  period_ff    <= cmd_period;
                  countdown_ff <= cmd_period;
                  live_ff      <= 1'b1;
               end
            end
            OP_DELETE: begin
               if (match_o) begin
                  live_ff <= 1'b0;
               end
            end
            OP_TICK: begin
               if (live_ff) begin
                  if (dec == '0) begin
                     countdown_ff <= period_ff;
                     ready_ff     <= 1'b1;
                  end else begin
                     countdown_ff <= dec;
                  end
               end
            end
            OP_CLEAR: begin
               if (mine) begin
                  ready_ff <= 1'b0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // selection wave, one cell per cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         cand_valid_ff <= 1'b0;
      end else begin
         cand_valid_ff <= take_own || cand_valid_i;
      end
      if (take_own) begin
         cand_pri_ff  <= pri_ff;
         cand_tag_ff  <= tag_ff;
         cand_slot_ff <= IDX_W'(SLOT);
      end else begin
         cand_pri_ff  <= cand_pri_i;
         cand_tag_ff  <= cand_tag_i;
         cand_slot_ff <= cand_slot_i;
      end
   end

   assign cand_valid_o = cand_valid_ff;
   assign cand_pri_o   = cand_pri_ff;
   assign cand_tag_o   = cand_tag_ff;
   assign cand_slot_o  = cand_slot_ff;

endmodule

/* rtl/core/periodic_priority_task_scheduler.sv */
// Periodic task scheduler with priorities. Each task slot lives in one cell of a
// chain; slots are filled in order by create words and never reused. Create and
// delete words each give one response word. A tick word updates all countdowns
// together, then a selection wave runs through the cell chain, one cell per
// cycle, and one dispatch word is given per ready task (highest priority first,
// lowest slot on ties), each once the response register is free.
// A tick with nothing ready gives one word with dispatched low. A new request
// word is taken only while no tick is in progress and the response register
// is free or being emptied in the same cycle.
module periodic_priority_task_scheduler
   import pst_pkg::*;
#(
   parameter int MAX_TASKS   = MAX_TASKS_DEF,
   parameter int PERIOD_BITS = PERIOD_BITS_DEF
) (
   input logic      clock,
   input logic      reset,
   pst_req_if.sink  req_chan,
   pst_rsp_if.source rsp_chan
);

   localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
   localparam int CNT_W = $clog2(MAX_TASKS + 1);

   typedef enum logic {
      S_IDLE,
      S_SCAN
   } state_type;

   state_type    state_ff, state_in;
   logic [CNT_W-1:0] used_ff, used_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   cell_cmd_type           cmd;
   logic [PERIOD_BITS-1:0] cmd_period;
   logic [IDX_W-1:0]       cmd_idx;

   logic                 cand_valid [MAX_TASKS+1];
   logic [PRI_W-1:0]     cand_pri   [MAX_TASKS+1];
   logic [TAG_W-1:0]     cand_tag   [MAX_TASKS+1];
   logic [IDX_W-1:0]     cand_slot  [MAX_TASKS+1];
   logic [MAX_TASKS-1:0] ready_vec;
   logic [MAX_TASKS-1:0] match_vec;

   logic out_free;
   logic accept;
   logic others_ready;
   logic win_valid;
   logic [IDX_W-1:0] win_slot;

   // empty candidate enters the bottom of the chain
   assign cand_valid[0] = 1'b0;
   assign cand_pri[0]   = '0;
   assign cand_tag[0]   = '0;
   assign cand_slot[0]  = '0;

   for (genvar g = 0; g < MAX_TASKS; g++) begin : g_cell
      pst_cell #(
         .PERIOD_BITS (PERIOD_BITS),
         .IDX_W       (IDX_W),
         .SLOT        (g)
      ) u_cell (
         .clock        (clock),
         .reset        (reset),
         .cmd          (cmd),
         .cmd_period   (cmd_period),
         .cmd_idx      (cmd_idx),
         .cand_valid_i (cand_valid[g]),
         .cand_pri_i   (cand_pri[g]),
         .cand_tag_i   (cand_tag[g]),
         .cand_slot_i  (cand_slot[g]),
         .cand_valid_o (cand_valid[g+1]),
         .cand_pri_o   (cand_pri[g+1]),
         .cand_tag_o   (cand_tag[g+1]),
         .cand_slot_o  (cand_slot[g+1]),
         .ready_o      (ready_vec[g]),
         .match_o      (match_vec[g])
      );
   end

   assign win_valid = cand_valid[MAX_TASKS];
   assign win_slot  = cand_slot[MAX_TASKS];

   assign out_free        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready  = (state_ff == S_IDLE) && out_free;
   assign accept          = req_chan.valid && req_chan.ready;
   assign rsp_chan.valid  = rsp_valid_ff;
   assign rsp_chan.payload = rsp_word_ff;

   // any ready task left besides the winner
   always_comb begin
      others_ready = 1'b0;
      for (int k = 0; k < MAX_TASKS; k++) begin
         if (ready_vec[k] && (IDX_W'(k) != win_slot)) begin
            others_ready = 1'b1;
         end
      end
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      used_in      = used_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_chan.ready;
      rsp_word_in  = rsp_word_ff;
      cmd.op       = OP_NONE;
      cmd.tag      = req_chan.payload.task_tag;
      cmd.pri      = req_chan.payload.priority_req;
      cmd_period   = PERIOD_BITS'(req_chan.payload.period);
      cmd_idx      = used_ff[IDX_W-1:0];

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               rsp_word_in.status     = ST_OK;
               rsp_word_in.dispatched = 1'b0;
               rsp_word_in.run_tag    = '0;
               rsp_word_in.last       = 1'b1;
               case (kind_type'(req_chan.payload.kind))
                  KIND_CREATE: begin
                     rsp_valid_in = 1'b1;
                     if (cmd_period == '0) begin
                        rsp_word_in.status = ST_ZERO_PERIOD;
                     end else if (used_ff == CNT_W'(MAX_TASKS)) begin
                        rsp_word_in.status = ST_FULL;
                     end else begin
                        cmd.op  = OP_CREATE;
                        used_in = used_ff + CNT_W'(1);
                     end
                  end
                  KIND_DELETE: begin
                     rsp_valid_in = 1'b1;
                     cmd.op       = OP_DELETE;
                     if (match_vec == '0) begin
                        rsp_word_in.status = ST_NOT_FOUND;
                     end
                  end
                  KIND_TICK: begin
                     cmd.op   = OP_TICK;
                     cnt_in   = '0;
                     state_in = S_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (cnt_ff != CNT_W'(MAX_TASKS)) begin
               cnt_in = cnt_ff + CNT_W'(1);
            end else if (out_free) begin
               rsp_valid_in           = 1'b1;
               rsp_word_in.status     = ST_OK;
               rsp_word_in.dispatched = win_valid;
               rsp_word_in.run_tag    = win_valid ? cand_tag[MAX_TASKS] : '0;
               rsp_word_in.last       = !(win_valid && others_ready);
               if (win_valid) begin
                  cmd.op  = OP_CLEAR;
                  cmd_idx = win_slot;
               end
               if (win_valid && others_ready) begin
                  cnt_in = '0;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         used_ff      <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

endmodule

/* dv/tb_periodic_priority_task_scheduler.sv */
module tb_periodic_priority_task_scheduler;
   import pst_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int NTASK      = MAX_TASKS_DEF;
   localparam int N_RANDOM   = 305;
   localparam int IDLE_LIMIT = 2000;
   localparam int MAX_GAP    = 20;
   localparam int DRAIN_WAIT = 100;

   // Directed row: request word, plus a hand-written response where one applies
   typedef struct packed {
      req_word_type word;
      logic         pinned;
      rsp_word_type want;
   } stim_row_type;

   typedef struct packed {
      logic         pinned;
      rsp_word_type want;
   } typed_rsp_type;

   localparam rsp_word_type RSP_NONE      = '0;
   localparam rsp_word_type RSP_OK        = '{ST_OK, 1'b0, 8'h00, 1'b1};
   localparam rsp_word_type RSP_NOT_FOUND = '{ST_NOT_FOUND, 1'b0, 8'h00, 1'b1};
   localparam rsp_word_type RSP_ZERO_PER  = '{ST_ZERO_PERIOD, 1'b0, 8'h00, 1'b1};

   localparam int N_DIRECTED = 19;
   localparam stim_row_type DIRECTED [N_DIRECTED] = '{
      // empty table: tick gives the idle word, delete misses, zero period rejected
      '{'{KIND_TICK,   8'h00, 16'h0000, 8'h00}, 1'b1, RSP_OK},
      '{'{KIND_DELETE, 8'h00, 16'h0000, 8'h00}, 1'b1, RSP_NOT_FOUND},
      '{'{KIND_CREATE, 8'hFF, 16'h0000, 8'hFF}, 1'b1, RSP_ZERO_PER},
      // unused kind is dropped without a response
      '{'{KIND_UNUSED, 8'hFF, 16'hFFFF, 8'hFF}, 1'b0, RSP_NONE},
      // fill slots 0..4, priority extremes, a tie and a duplicate tag
      '{'{KIND_CREATE, 8'hA5, 16'h0001, 8'h00}, 1'b1, RSP_OK},
      '{'{KIND_CREATE, 8'h5A, 16'hFFFF, 8'hFF}, 1'b1, RSP_OK},
      '{'{KIND_CREATE, 8'h11, 16'h0002, 8'h80}, 1'b1, RSP_OK},
      '{'{KIND_CREATE, 8'h22, 16'h0001, 8'h80}, 1'b1, RSP_OK},
      '{'{KIND_CREATE, 8'h11, 16'h0003, 8'h7F}, 1'b1, RSP_OK},
      '{'{KIND_TICK,   8'h00, 16'h0000, 8'h00}, 1'b0, RSP_NONE},
      '{'{KIND_TICK,   8'h00, 16'h0000, 8'h00}, 1'b0, RSP_NONE},
      // delete kills both copies of the tag, a second delete misses
      '{'{KIND_DELETE, 8'h11, 16'h0000, 8'h00}, 1'b1, RSP_OK},
      '{'{KIND_DELETE, 8'h11, 16'h0000, 8'h00}, 1'b1, RSP_NOT_FOUND},
      '{'{KIND_TICK,   8'h00, 16'h0000, 8'h00}, 1'b0, RSP_NONE},
      '{'{KIND_DELETE, 8'h5A, 16'h0000, 8'h00}, 1'b1, RSP_OK},
      '{'{KIND_TICK,   8'h00, 16'h0000, 8'h00}, 1'b0, RSP_NONE},
      '{'{KIND_DELETE, 8'hA5, 16'h0000, 8'h00}, 1'b1, RSP_OK},
      '{'{KIND_DELETE, 8'h22, 16'h0000, 8'h00}, 1'b1, RSP_OK},
      // dead slots stay allocated but never fire
      '{'{KIND_TICK,   8'h00, 16'h0000, 8'h00}, 1'b1, RSP_OK}
   };

   logic clock = 1'b0;
   logic reset;

   pst_req_if req_chan ();
   pst_rsp_if rsp_chan ();

   periodic_priority_task_scheduler uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Scheduler state as the checker sees it
   logic [TAG_W-1:0]    slot_tag    [NTASK];
   logic [PERIOD_W-1:0] slot_period [NTASK];
   logic [PERIOD_W-1:0] slot_count  [NTASK];
   logic [PRI_W-1:0]    slot_pri    [NTASK];
   logic [NTASK-1:0]    slot_live;
   int                  slots_used;

   rsp_word_type  rsp_due_q [$];
   typed_rsp_type typed_rsp_q [$];

   // Stimulus-side bookkeeping of allocated slots and live tags
   int               alloc_n;
   logic [TAG_W-1:0] live_tags [$];

   int fail_count;
   int idle_cycles;
   int send_idle_pct;
   int stall_pct;

   // Work out the response words that one request word causes
   function automatic void forecast_rsp(req_word_type w);
      rsp_word_type     r;
      logic [NTASK-1:0] fired;
      int               n_fired;
      int               best;
      int               i;
      int               k;
      logic             hit;
      r = '{status: ST_OK, dispatched: 1'b0, run_tag: '0, last: 1'b1};
      case (w.kind)
         KIND_CREATE: begin
            if (w.period == '0) begin
               r.status = ST_ZERO_PERIOD;
            end else if (slots_used >= NTASK) begin
               r.status = ST_FULL;
            end else begin
               slot_tag[slots_used]    = w.task_tag;
               slot_period[slots_used] = w.period;
               slot_count[slots_used]  = w.period;
               slot_pri[slots_used]    = w.priority_req;
               slot_live[slots_used]   = 1'b1;
               slots_used++;
            end
            rsp_due_q.push_back(r);
         end
         KIND_DELETE: begin
            hit = 1'b0;
            for (i = 0; i < slots_used; i++) begin
               if (slot_live[i] && slot_tag[i] == w.task_tag) begin
                  slot_live[i] = 1'b0;
                  hit = 1'b1;
               end
            end
            if (!hit) r.status = ST_NOT_FOUND;
            rsp_due_q.push_back(r);
         end
         KIND_TICK: begin
            fired = '0;
            n_fired = 0;
            for (i = 0; i < slots_used; i++) begin
               if (slot_live[i]) begin
                  slot_count[i] = slot_count[i] - PERIOD_W'(1);
                  if (slot_count[i] == '0) begin
                     fired[i] = 1'b1;
                     slot_count[i] = slot_period[i];
                     n_fired++;
                  end
               end
            end
            if (n_fired == 0) rsp_due_q.push_back(r);
            // highest priority first, strict compare keeps the lowest slot on ties
            for (k = 0; k < n_fired; k++) begin
               best = -1;
               for (i = 0; i < NTASK; i++) begin
                  if (fired[i] && (best < 0 || slot_pri[i] > slot_pri[best])) best = i;
               end
               fired[best] = 1'b0;
               r.dispatched = 1'b1;
               r.run_tag = slot_tag[best];
               r.last = (k == n_fired - 1);
               rsp_due_q.push_back(r);
            end
         end
         default: begin
         end
      endcase
   endfunction

   // Track which tags the stimulus may still hit with a delete
   function automatic void note_word(req_word_type w);
      int i;
      if (w.kind == KIND_CREATE && w.period != '0 && alloc_n < NTASK) begin
         alloc_n++;
         live_tags.push_back(w.task_tag);
      end else if (w.kind == KIND_DELETE) begin
         for (i = live_tags.size() - 1; i >= 0; i--) begin
            if (live_tags[i] == w.task_tag) live_tags.delete(i);
         end
      end
   endfunction

   // Drive one request word and hold it until taken, then maybe idle a while
   task automatic send_word(req_word_type w, logic pinned, rsp_word_type want);
      int gap;
      typed_rsp_q.push_back('{pinned, want});
      note_word(w);
      req_chan.valid   <= 1'b1;
      req_chan.payload <= w;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      gap = 0;
      while (gap < MAX_GAP && $urandom_range(0, 99) < send_idle_pct) begin
         if (gap == 0) req_chan.valid <= 1'b0;
         gap++;
         @(posedge clock);
      end
   endtask

   // Response side back-pressure
   always @(posedge clock) begin
      rsp_chan.ready <= ($urandom_range(0, 99) >= stall_pct);
   end

   // Monitor both channels: predict on accepted requests, check accepted responses
   always @(posedge clock) begin
      typed_rsp_type pin;
      rsp_word_type  want;
      rsp_word_type  got;
      if (reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (req_chan.valid && req_chan.ready) begin
            idle_cycles = 0;
            pin = typed_rsp_q.pop_front();
            forecast_rsp(req_chan.payload);
            if (pin.pinned) rsp_due_q[rsp_due_q.size() - 1] = pin.want;
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            idle_cycles = 0;
            got = rsp_chan.payload;
            if (rsp_due_q.size() == 0) begin
               fail_count++;
               $display("%0t: unexpected word status=%0d dispatched=%0d run_tag=%02h last=%0d",
                        $time, got.status, got.dispatched, got.run_tag, got.last);
            end else begin
               want = rsp_due_q.pop_front();
               if (got.status !== want.status || got.dispatched !== want.dispatched ||
                   got.run_tag !== want.run_tag || got.last !== want.last) begin
                  fail_count++;
                  $display("%0t: mismatch expected status=%0d dispatched=%0d run_tag=%02h last=%0d",
                           $time, want.status, want.dispatched, want.run_tag, want.last);
                  $display("%0t:          actual   status=%0d dispatched=%0d run_tag=%02h last=%0d",
                           $time, got.status, got.dispatched, got.run_tag, got.last);
               end
            end
         end
      end
   end

   // Watchdog on cycles with no word moving on either channel
   initial begin
      while (idle_cycles < IDLE_LIMIT) @(posedge clock);
      $display("tb_periodic_priority_task_scheduler: errors");
      $finish;
   end

   initial begin
      req_word_type w;
      int           row;
      int           sent;
      int           pick;
      int           phase;
      fail_count       = 0;
      idle_cycles      = 0;
      send_idle_pct    = 0;
      stall_pct        = 0;
      alloc_n          = 0;
      slots_used       = 0;
      slot_live        = '0;
      reset            = 1'b1;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      rsp_chan.ready   = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Directed rows
      for (row = 0; row < N_DIRECTED; row++) begin
         send_word(DIRECTED[row].word, DIRECTED[row].pinned, DIRECTED[row].want);
      end

      // Random words: mostly ticks over a table filled with random tasks;
      // the remaining creates run into the full table since slots are not recycled
      sent = 0;
      while (sent < N_RANDOM) begin
         phase = sent * 4 / N_RANDOM;
         case (phase)
            0: begin send_idle_pct = 0;  stall_pct = 0;  end
            1: begin send_idle_pct = 60; stall_pct = 0;  end
            2: begin send_idle_pct = 0;  stall_pct = 60; end
            default: begin send_idle_pct = 24; stall_pct = 24; end
         endcase
         w.kind         = KIND_TICK;
         w.task_tag     = TAG_W'($urandom_range(0, 255));
         w.period       = PERIOD_W'($urandom_range(0, 65535));
         w.priority_req = PRI_W'($urandom_range(0, 255));
         pick = $urandom_range(0, 99);
         if (pick < 3) begin
            w.kind = KIND_UNUSED;
         end else if (pick < 23) begin
            w.kind = KIND_CREATE;
            // small tag pool gives duplicates, small priorities give ties
            if ($urandom_range(0, 1) == 0) w.task_tag = $urandom_range(0, 1) ? 8'h3C : 8'hC3;
            case ($urandom_range(0, 9))
               0: w.period = '0;
               1: w.period = PERIOD_W'($urandom_range(1, 65535));
               default: w.period = PERIOD_W'($urandom_range(1, 6));
            endcase
            if ($urandom_range(0, 1) == 0) w.priority_req = PRI_W'($urandom_range(0, 3));
         end else if (pick < 31) begin
            w.kind = KIND_DELETE;
            // spare the last few live tasks until near the end
            if ((live_tags.size() > 3 || (N_RANDOM - sent < 40 && live_tags.size() > 0)) &&
                $urandom_range(0, 2) == 0) begin
               w.task_tag = live_tags[$urandom_range(0, live_tags.size() - 1)];
            end
         end
         send_word(w, 1'b0, RSP_NONE);
         if (w.kind != KIND_UNUSED) sent++;
      end

      // Drain outstanding responses, then watch for strays
      req_chan.valid <= 1'b0;
      stall_pct = 0;
      while (rsp_due_q.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0 && rsp_due_q.size() == 0) begin
         $display("tb_periodic_priority_task_scheduler: clean");
      end else begin
         $display("tb_periodic_priority_task_scheduler: errors");
      end
      $finish;
   end

endmodule

/* files.f */
rtl/core/pst_pkg.sv
rtl/core/pst_if.sv
rtl/core/pst_cell.sv
rtl/core/periodic_priority_task_scheduler.sv
dv/tb_periodic_priority_task_scheduler.sv
